// ===== rtl/core/lru_slot_cache_assert.svh =====
// assertion macros used by the lru slot cache port checker
`ifndef LRU_SLOT_CACHE_ASSERT_SVH
`define LRU_SLOT_CACHE_ASSERT_SVH

// same-cycle implication, held off while reset is low
`define LSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("lru slot cache check failed");

// next-cycle implication, held off while reset is low
`define LSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("lru slot cache check failed");

`endif

// ===== rtl/core/lsc_pkg.sv =====
// shared constants, types and chain structs of the lru slot cache
package lsc_pkg;

  localparam int SLOTS      = 16;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int CNT_W      = $clog2(SLOTS + 1);
  localparam int KEY_W      = 32;
  localparam int PAY_W      = 32;
  localparam int CAP_W      = 5;
  localparam int SLOT_IDX_W = 4;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_PROMOTE = 2'd1,
    ACT_INSTALL = 2'd2
  } act_t;

  // broadcast to every cell for the compare pass
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] vrank;
  } probe_t;

  // result of the compare pass, rippled from cell to cell
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] hslot;
    logic [SLOT_W-1:0] hrank;
    logic [PAY_W-1:0]  hpay;
    logic              vict;
    logic [SLOT_W-1:0] vslot;
  } scan_t;

  // update broadcast to every cell
  typedef struct packed {
    act_t              act;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] ref_rank;
    logic              wr_key;
    logic              wr_pay;
    logic [KEY_W-1:0]  key;
    logic [PAY_W-1:0]  pay;
  } cmd_t;

endpackage

// ===== rtl/core/lsc_if.sv =====
// channel interfaces of the lru slot cache
interface lsc_req_if;
  logic                     valid;
  logic                     ready;
  logic                     op;
  logic [lsc_pkg::KEY_W-1:0] key_tag;
  logic [lsc_pkg::PAY_W-1:0] payload;

  modport source (output valid, op, key_tag, payload, input ready);
  modport sink   (input valid, op, key_tag, payload, output ready);
endinterface

interface lsc_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [lsc_pkg::SLOT_IDX_W-1:0] slot_index;
  logic [lsc_pkg::PAY_W-1:0]      entry_payload;
  logic                          entry_valid;
  logic                          evicted;

  modport source (output valid, found, slot_index, entry_payload, entry_valid, evicted,
                  input ready);
  modport sink   (input valid, found, slot_index, entry_payload, entry_valid, evicted,
                  output ready);
endinterface

interface lsc_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [lsc_pkg::CAP_W-1:0] capacity;

  modport source (output valid, capacity, input ready);
  modport sink   (input valid, capacity, output ready);
endinterface

// ===== rtl/core/lsc_cell.sv =====
// one slot of the lru table: key, payload, used flag and recency rank
module lsc_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [lsc_pkg::SLOT_W-1:0] idx,
  input  lsc_pkg::probe_t            probe,
  input  lsc_pkg::cmd_t              cmd,
  input  lsc_pkg::scan_t             scan_i,
  output lsc_pkg::scan_t             scan_o
);

  logic                       used_r, used_nxt;
  logic [lsc_pkg::SLOT_W-1:0] rank_r, rank_nxt;
  logic [lsc_pkg::KEY_W-1:0]  key_r;
  logic [lsc_pkg::PAY_W-1:0]  pay_r;
  logic                       match, vmatch, self;

  assign match  = used_r && (key_r == probe.key);
  assign vmatch = used_r && (rank_r == probe.vrank);
  assign self   = (cmd.slot == idx);

  // first match along the chain wins
  always_comb begin
    scan_o = scan_i;
    if (!scan_i.hit && match) begin
      scan_o.hit   = 1'b1;
      scan_o.hslot = idx;
      scan_o.hrank = rank_r;
      scan_o.hpay  = pay_r;
    end
    if (!scan_i.vict && vmatch) begin
      scan_o.vict  = 1'b1;
      scan_o.vslot = idx;
    end
  end

  always_comb begin
    used_nxt = used_r;
    rank_nxt = rank_r;
    unique case (cmd.act)
      lsc_pkg::ACT_PROMOTE: begin
        if (self) begin
          rank_nxt = '0;
        end else if (used_r && (rank_r < cmd.ref_rank)) begin
          rank_nxt = rank_r + 1'b1;
        end
      end
      lsc_pkg::ACT_INSTALL: begin
        if (self) begin
          rank_nxt = '0;
          used_nxt = 1'b1;
        end else if (used_r) begin
          rank_nxt = rank_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
      rank_r <= '0;
    end else begin
      used_r <= used_nxt;
      rank_r <= rank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_key && self) begin
      key_r <= cmd.key;
    end
    if (cmd.wr_pay && self) begin
      pay_r <= cmd.pay;
    end
  end

endmodule

// ===== rtl/core/lru_slot_cache.sv =====
// top level of the lru slot cache: request stage, cell chain and result register
// Fully associative LRU table of 16 slots mapping a 32-bit key tag to a slot
// index and a 32-bit payload. op 0 looks a key up (a hit makes the entry most
// recent), op 1 puts it (a hit updates the payload, a miss fills the next free
// slot while the fill count is below capacity, otherwise the least recent entry
// is evicted and its slot reused). Each input beat is registered; once the result
// register is free or draining, the request runs once along the row of slot
// cells, which compare the key, find the victim by its rank and apply the rank
// and payload update; the result lands in the output register. One item per
// cycle is sustained while results are taken; a stalled result register holds
// back one further item. Capacity is written on the cfg channel (0 counts as 1,
// above 16 as 16); the user must write it only while idle, and the block itself
// does not enforce this. No clearing pass runs after reset: used flags guard slots.
module lru_slot_cache (
  input  logic      clk,
  input  logic      rst_n,
  lsc_req_if.sink   in_req,
  lsc_rsp_if.source out_rsp,
  lsc_cfg_if.sink   cfg_wr
);

  localparam int SLOTS  = lsc_pkg::SLOTS;
  localparam int SLOT_W = lsc_pkg::SLOT_W;
  localparam int CNT_W  = lsc_pkg::CNT_W;

  // capacity register
  logic [lsc_pkg::CAP_W-1:0] cap_r;
  logic [CNT_W-1:0]          cap_eff;

  // no beat is taken while reset is held
  assign cfg_wr.ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lsc_pkg::CAP_RESET;
    end else if (cfg_wr.valid) begin
      cap_r <= cfg_wr.capacity;
    end
  end

  // clamp to 1..SLOTS
  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CNT_W'(1);
    end else if (32'(cap_r) > 32'(SLOTS)) begin
      cap_eff = CNT_W'(SLOTS);
    end else begin
      cap_eff = CNT_W'(cap_r);
    end
  end

  // request stage
  logic                      req_v_r;
  logic                      req_op_r;
  logic [lsc_pkg::KEY_W-1:0] req_key_r;
  logic [lsc_pkg::PAY_W-1:0] req_pay_r;
  logic                      out_valid_r;
  logic                      fire;
  logic                      in_beat;

  // request is applied when the result register is free or draining
  assign fire         = req_v_r && (!out_valid_r || out_rsp.ready);
  assign in_req.ready = rst_n && (!req_v_r || fire);
  assign in_beat      = in_req.valid && in_req.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_v_r <= 1'b0;
    end else if (in_beat) begin
      req_v_r <= 1'b1;
    end else if (fire) begin
      req_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      req_op_r  <= in_req.op;
      req_key_r <= in_req.key_tag;
      req_pay_r <= in_req.payload;
    end
  end

  // fill counter
  logic [CNT_W-1:0] fill_cnt_r, fill_cnt_nxt;

  // cell chain
  lsc_pkg::probe_t probe;
  lsc_pkg::cmd_t   cmd;
  lsc_pkg::scan_t  scan [SLOTS+1];
  lsc_pkg::scan_t  res;

  // least recent used entry carries rank fill_count - 1
  assign probe.key   = req_key_r;
  assign probe.vrank = SLOT_W'(fill_cnt_r - 1'b1);
  assign scan[0]     = '0;

  genvar gi;
  generate
    for (gi = 0; gi < SLOTS; gi++) begin : g_cell
      lsc_cell u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .idx    (SLOT_W'(gi)),
        .probe  (probe),
        .cmd    (cmd),
        .scan_i (scan[gi]),
        .scan_o (scan[gi+1])
      );
    end
  endgenerate

  assign res = scan[SLOTS];

  // put decisions
  logic              is_put;
  logic              fill_ok;
  logic              do_evict;
  logic [SLOT_W-1:0] tgt_slot;

  assign is_put   = req_op_r;
  assign fill_ok  = !res.hit && (fill_cnt_r < cap_eff);
  assign do_evict = is_put && !res.hit && !fill_ok;

  always_comb begin
    if (res.hit) begin
      tgt_slot = res.hslot;
    end else if (fill_ok) begin
      tgt_slot = SLOT_W'(fill_cnt_r);
    end else begin
      tgt_slot = res.vslot;
    end
  end

  always_comb begin
    cmd.act      = lsc_pkg::ACT_NONE;
    cmd.slot     = tgt_slot;
    cmd.ref_rank = res.hrank;
    cmd.wr_key   = fire && is_put && !res.hit;
    cmd.wr_pay   = fire && is_put;
    cmd.key      = req_key_r;
    cmd.pay      = req_pay_r;
    if (fire) begin
      if (res.hit) begin
        cmd.act = lsc_pkg::ACT_PROMOTE;
      end else if (is_put) begin
        cmd.act = lsc_pkg::ACT_INSTALL;
      end
    end
  end

  always_comb begin
    fill_cnt_nxt = fill_cnt_r;
    if (fire && is_put && fill_ok) begin
      fill_cnt_nxt = fill_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_cnt_r <= '0;
    end else begin
      fill_cnt_r <= fill_cnt_nxt;
    end
  end

  // result register
  logic                           out_valid_nxt;
  logic                           found_r;
  logic [lsc_pkg::SLOT_IDX_W-1:0] slot_r;
  logic [lsc_pkg::PAY_W-1:0]      pay_r;
  logic                           ent_valid_r;
  logic                           evicted_r;

  assign out_valid_nxt = fire || (out_valid_r && !out_rsp.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // a missed lookup reports all zero
  always_ff @(posedge clk) begin
    if (fire) begin
      found_r     <= res.hit;
      ent_valid_r <= is_put || res.hit;
      evicted_r   <= do_evict;
      if (is_put) begin
        slot_r <= lsc_pkg::SLOT_IDX_W'(tgt_slot);
        pay_r  <= req_pay_r;
      end else if (res.hit) begin
        slot_r <= lsc_pkg::SLOT_IDX_W'(res.hslot);
        pay_r  <= res.hpay;
      end else begin
        slot_r <= '0;
        pay_r  <= '0;
      end
    end
  end

  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.found         = found_r;
  assign out_rsp.slot_index    = slot_r;
  assign out_rsp.entry_payload = pay_r;
  assign out_rsp.entry_valid   = ent_valid_r;
  assign out_rsp.evicted       = evicted_r;

endmodule

// ===== rtl/core/lsc_checker.sv =====
// port-level checker of the lru slot cache and its bind
`include "lru_slot_cache_assert.svh"

module lsc_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           out_found,
  input logic [lsc_pkg::SLOT_IDX_W-1:0] out_slot_index,
  input logic [lsc_pkg::PAY_W-1:0]      out_entry_payload,
  input logic                           out_entry_valid,
  input logic                           out_evicted
);

  // a stalled result beat holds
  `LSC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_slot_index) && $stable(out_entry_payload))

  // a missed lookup reports all zero
  `LSC_ASSERT_IMP(a_miss_zero, clk, rst_n, out_valid && !out_entry_valid, !out_found && (out_slot_index == '0) && (out_entry_payload == '0) && !out_evicted)

  // a hit never evicts
  `LSC_ASSERT_IMP(a_hit_no_evict, clk, rst_n, out_valid, !(out_found && out_evicted))

  // hit or eviction always returns a slot
  `LSC_ASSERT_IMP(a_slot_returned, clk, rst_n, out_valid && (out_found || out_evicted), out_entry_valid)

endmodule

bind lru_slot_cache lsc_checker u_lsc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_rsp.valid),
  .out_ready         (out_rsp.ready),
  .out_found         (out_rsp.found),
  .out_slot_index    (out_rsp.slot_index),
  .out_entry_payload (out_rsp.entry_payload),
  .out_entry_valid   (out_rsp.entry_valid),
  .out_evicted       (out_rsp.evicted)
);

// ===== verif/lsc_tb_pkg.sv =====
// request operation codes shared by the lru slot cache testbench files
`timescale 1ns / 100ps
package lsc_tb_pkg;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } lsc_op_t;

endpackage

// ===== verif/lru_slot_checker.sv =====
// checker of the lru slot cache: tracks the table, predicts each result beat and compares
`timescale 1ns / 100ps
module lru_slot_checker (
  input  logic clk,
  input  logic rst_n,
  lsc_req_if   req,
  lsc_rsp_if   rsp,
  lsc_cfg_if   cfg,
  output int   fail_count,
  output int   outstanding,
  output int   hit_count,
  output int   miss_count,
  output int   evict_count
);
  import lsc_pkg::*;
  import lsc_tb_pkg::*;

  typedef struct packed {
    logic                  found;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic [PAY_W-1:0]      entry_payload;
    logic                  entry_valid;
    logic                  evicted;
  } slot_result_t;

  // table copy
  logic [KEY_W-1:0] tag_of[SLOTS];
  logic [PAY_W-1:0] payload_of[SLOTS];
  logic             in_use[SLOTS];
  int               age_of[SLOTS];
  int               filled;
  logic [CAP_W-1:0] capacity_q;

  slot_result_t expected_slot_results[$];
  slot_result_t want;

  initial begin
    fail_count  = 0;
    outstanding = 0;
    hit_count   = 0;
    miss_count  = 0;
    evict_count = 0;
  end

  function automatic void make_most_recent(int s);
    int i;
    int r;
    r = age_of[s];
    for (i = 0; i < SLOTS; i++)
      if (in_use[i] && i != s && age_of[i] < r) age_of[i]++;
    age_of[s] = 0;
  endfunction

  function automatic void install_newest(int s);
    int i;
    for (i = 0; i < SLOTS; i++)
      if (in_use[i] && i != s) age_of[i]++;
    age_of[s] = 0;
    in_use[s] = 1'b1;
  endfunction

  function automatic slot_result_t predict_slot_access(lsc_op_t op, logic [KEY_W-1:0] key,
                                                       logic [PAY_W-1:0] pay);
    slot_result_t res;
    int           eff_cap;
    int           hit_slot;
    int           slot;
    int           worst;
    int           i;
    logic         hit;
    logic         any;
    res      = '0;
    hit      = 1'b0;
    any      = 1'b0;
    hit_slot = 0;
    slot     = 0;
    worst    = 0;
    // zero counts as one, anything above the slot count as the slot count
    if (capacity_q == '0) eff_cap = 1;
    else if (capacity_q > SLOTS) eff_cap = SLOTS;
    else eff_cap = int'(capacity_q);
    for (i = 0; i < SLOTS; i++)
      if (!hit && in_use[i] && tag_of[i] == key) begin
        hit      = 1'b1;
        hit_slot = i;
      end
    if (op == OP_GET) begin
      if (hit) begin
        make_most_recent(hit_slot);
        res.found         = 1'b1;
        res.slot_index    = SLOT_IDX_W'(hit_slot);
        res.entry_payload = payload_of[hit_slot];
        res.entry_valid   = 1'b1;
        hit_count++;
      end else begin
        miss_count++;
      end
      return res;
    end
    if (hit) begin
      slot             = hit_slot;
      payload_of[slot] = pay;
      make_most_recent(slot);
      hit_count++;
    end else begin
      if (filled < eff_cap) begin
        slot = filled;
        filled++;
      end else begin
        for (i = 0; i < SLOTS; i++)
          if (in_use[i] && (!any || age_of[i] > worst)) begin
            worst = age_of[i];
            slot  = i;
            any   = 1'b1;
          end
        res.evicted = any;
        if (any) evict_count++;
      end
      tag_of[slot]     = key;
      payload_of[slot] = pay;
      install_newest(slot);
    end
    res.found         = hit;
    res.slot_index    = SLOT_IDX_W'(slot);
    res.entry_payload = payload_of[slot];
    res.entry_valid   = 1'b1;
    return res;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_val, logic [31:0] got);
    if (exp_val !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_val, got);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_use     = '{default: 1'b0};
      age_of     = '{default: 0};
      filled     = 0;
      capacity_q = CAP_RESET;
      expected_slot_results.delete();
    end else begin
      if (cfg.valid && cfg.ready) capacity_q = cfg.capacity;
      if (rsp.valid && rsp.ready) begin
        if (expected_slot_results.size() == 0) begin
          fail_count++;
          $display("%0t: result beat with nothing expected, got slot 0x%0h payload 0x%0h",
                   $time, rsp.slot_index, rsp.entry_payload);
        end else begin
          want = expected_slot_results.pop_front();
          check_field("found", want.found, rsp.found);
          check_field("slot_index", want.slot_index, rsp.slot_index);
          check_field("entry_payload", want.entry_payload, rsp.entry_payload);
          check_field("entry_valid", want.entry_valid, rsp.entry_valid);
          check_field("evicted", want.evicted, rsp.evicted);
        end
      end
      if (req.valid && req.ready)
        expected_slot_results.push_back(
          predict_slot_access(lsc_op_t'(req.op), req.key_tag, req.payload));
    end
    outstanding = expected_slot_results.size();
  end

endmodule

// ===== verif/tb_lru_slot_cache.sv =====
// top of the lru slot cache testbench: clock, reset, request and capacity stimulus, verdict
`timescale 1ns / 100ps
module tb_lru_slot_cache;
  import lsc_pkg::*;
  import lsc_tb_pkg::*;

  // length of the receiver hold-off that backs the block up into its input
  localparam int HOLD_OFF_CYCLES = 40;

  logic clk;
  logic rst_n;

  lsc_req_if in_req ();
  lsc_rsp_if out_rsp ();
  lsc_cfg_if cfg_wr ();

  int fail_count;
  int outstanding;
  int hit_count;
  int miss_count;
  int evict_count;

  // idle and stall rates in percent of cycles, changed per phase
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  // set by the stimulus, picked up and counted down by the receiver
  bit hold_off_req   = 1'b0;
  int hold_off_left  = 0;
  int sent_count     = 0;
  int cap_writes     = 0;

  lru_slot_cache u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp),
    .cfg_wr  (cfg_wr)
  );

  lru_slot_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (in_req),
    .rsp         (out_rsp),
    .cfg         (cfg_wr),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .hit_count   (hit_count),
    .miss_count  (miss_count),
    .evict_count (evict_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // overall limit, far above the slowest legal run
  initial begin
    #2_000_000;
    $display("[lru_slot_cache] ERROR");
    $finish;
  end

  // receiver: random back-pressure, or a long hold-off when asked for one
  initial begin
    out_rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        out_rsp.ready <= 1'b0;
        hold_off_left--;
      end else if (hold_off_req) begin
        hold_off_req  = 1'b0;
        hold_off_left = HOLD_OFF_CYCLES - 1;
        out_rsp.ready <= 1'b0;
      end else begin
        out_rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // offer one request beat; entered and left at a falling edge, valid stays up on exit
  task automatic send_request(lsc_op_t op, logic [KEY_W-1:0] key, logic [PAY_W-1:0] pay);
    while ($urandom_range(99) < send_idle_pct) begin
      in_req.valid <= 1'b0;
      @(negedge clk);
    end
    in_req.valid   <= 1'b1;
    in_req.op      <= op;
    in_req.key_tag <= key;
    in_req.payload <= pay;
    // ready is sampled at the rising edge, before the block updates it
    do @(posedge clk); while (!in_req.ready);
    sent_count++;
    @(negedge clk);
  endtask

  // stop offering and wait until every predicted result beat has been taken
  task automatic drain_results();
    in_req.valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  // capacity is only changed with the table idle
  task automatic write_capacity(logic [CAP_W-1:0] cap);
    drain_results();
    // a short pause after the drain leaves the pipeline empty
    repeat (4) @(negedge clk);
    cfg_wr.valid    <= 1'b1;
    cfg_wr.capacity <= cap;
    do @(posedge clk); while (!cfg_wr.ready);
    cap_writes++;
    @(negedge clk);
    cfg_wr.valid <= 1'b0;
  endtask

  // random traffic over a small key pool so that hits, fills and evictions all occur
  task automatic run_phase(logic [CAP_W-1:0] cap, int n_items, int send_pct, int recv_pct,
                           int pool_size);
    logic [KEY_W-1:0] key_pool[$];
    logic [KEY_W-1:0] key;
    lsc_op_t          op;
    int               pick;
    int               i;
    write_capacity(cap);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (i = 0; i < pool_size; i++) key_pool.push_back($urandom);
    for (i = 0; i < n_items; i++) begin
      // back up the result side while requests keep coming
      if (i == n_items / 4) hold_off_req = 1'b1;
      // sender pause until the block has handed back everything
      if (i == n_items / 2) drain_results();
      op   = lsc_op_t'($urandom_range(1));
      pick = $urandom_range(99);
      if (pick < 88) key = key_pool[$urandom_range(pool_size - 1)];
      else if (pick < 91) key = '0;
      else if (pick < 94) key = '1;
      else key = $urandom;
      send_request(op, key, $urandom);
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    in_req.valid     = 1'b0;
    in_req.op        = OP_GET;
    in_req.key_tag   = '0;
    in_req.payload   = '0;
    cfg_wr.valid     = 1'b0;
    cfg_wr.capacity  = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: two slots, so eviction shows up after two fills
    write_capacity(5'd2);
    send_request(OP_GET, 32'h0000_0000, 32'h1234_5678);   // lookup in an empty table
    send_request(OP_PUT, 32'h0000_0000, 32'h0000_0000);
    send_request(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_GET, 32'h0000_0000, 32'h0000_0000);   // hit, key 0 becomes newest
    send_request(OP_PUT, 32'h0000_0001, 32'h0000_0005);   // full: evicts the all-ones key
    send_request(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);   // evicted key now misses
    send_request(OP_PUT, 32'h0000_0000, 32'hA5A5_A5A5);   // update on a hit
    send_request(OP_GET, 32'h0000_0001, 32'h0000_0000);

    // zero capacity acts as one, and sits below the fill count of two
    write_capacity(5'd0);
    send_request(OP_PUT, 32'h0000_0007, 32'h0000_0001);
    send_request(OP_PUT, 32'h0000_0008, 32'h5A5A_5A5A);
    send_request(OP_GET, 32'h0000_0008, 32'h0000_0000);
    send_request(OP_GET, 32'h0000_0007, 32'h0000_0000);

    // capacity above the slot count acts as the slot count
    write_capacity(5'd31);
    for (int n = 0; n < 6; n++)
      send_request(OP_PUT, 32'h8000_0000 + n, ~n);
    send_request(OP_GET, 32'h8000_0003, 32'h0000_0000);
    send_request(OP_GET, 32'h5A5A_5A5A, 32'h0000_0000);

    // random phases: sender lightly idle, receiver mostly stalled
    run_phase(5'd16, 500, 8, 73, 20);
    // then the other way round, with capacity cut below the fill count
    run_phase(5'd3, 450, 73, 8, 6);
    // then no idling on either side
    run_phase(5'd31, 500, 0, 0, 22);
    run_phase(5'd1, 420, 0, 0, 3);

    drain_results();
    repeat (8) @(posedge clk);

    $display("covered %0d requests under %0d capacity writes (zero, one, small, full, over-range)",
             sent_count, cap_writes);
    $display("saw %0d hits, %0d missed lookups and %0d evictions",
             hit_count, miss_count, evict_count);
    if (fail_count == 0 && outstanding == 0) begin
      $display("[lru_slot_cache] OK");
    end else begin
      $display("[lru_slot_cache] ERROR");
    end
    $finish;
  end

endmodule
